@@ rtl/core/dtptb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dtptb_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int MAX_NODES   = 1024;
   localparam int INDEX_W     = 10;
   localparam int VALUE_W     = 8;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_FIELD_W = 53;

   typedef enum logic [2:0] {
      OP_CHILD,
      OP_CHILD_PUSH,
      OP_SELF_LINK,
      OP_POP,
      OP_FULL,
      OP_LAST
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_TOO_MANY  = 2'd3
   } err_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      op_type             op;
   } work_type;

   localparam int WORK_W = $bits(work_type);

endpackage
`default_nettype wire

@@ rtl/core/dual_tag_preorder_tree_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// dual-tag preorder tree builder
// req channel: one transaction per node in preorder, tlast on the final node
//    of a tree. the front stage gives each node the next dense index and
//    classifies it, then hands it to a four-entry queue.
// rsp channel: one transaction per node with its index, value, child link,
//    any right-sibling link that the node settles, an error code and the
//    unterminated flag; tlast marks the end of the tree.
// an accepted req transaction passes through the queue and the output register
//    before rsp_tvalid. throughput is one node per cycle while rsp_tready holds
//    high: the back stage does one push or pop a cycle, with the top of the pending
//    stack in a register and the 64-entry stack ram prefetching the entry below it.
// reset clears the index counter, the stack count, the queue and the
//    output register; the stack ram needs no clearing.
// when the receiver holds rsp_tready low the output register keeps its
//    transaction, the queue fills, and req_tready drops once it is full.
module dual_tag_preorder_tree_builder
   import dtptb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // node_value, no_child, no_sibling, zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // node_index, node_value_out, child_present, child_index, link_valid,
   // link_owner, link_target, error_code, unterminated, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic     front_valid, front_ready;
   work_type front_data;
   logic     back_valid, back_ready;
   work_type back_data;

   dtptb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .work_valid (front_valid),
      .work_ready (front_ready),
      .work_data  (front_data)
   );

   dtptb_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_data  (front_data),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_data  (back_data)
   );

   dtptb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (back_valid),
      .work_ready (back_ready),
      .work_data  (back_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ rtl/core/dtptb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/dtptb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtptb_fifo
   import dtptb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_valid,
   output logic          wr_ready,
   input  wire work_type wr_data,
   output logic          rd_valid,
   input  wire logic     rd_ready,
   output work_type      rd_data
);

   work_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   assign wr_ready = (count_ff != (FIFO_AW + 1)'(FIFO_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/dtptb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtptb_front
   import dtptb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       work_valid,
   input  wire logic                  work_ready,
   output work_type                   work_data
);

   logic [INDEX_W-1:0] next_ff, next_in;
   logic               no_child, no_sibling, accept;

   assign no_child   = req_tdata[VALUE_W];
   assign no_sibling = req_tdata[VALUE_W+1];
   assign req_tready = work_ready;
   assign work_valid = req_tvalid;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      work_data.index = next_ff;
      work_data.value = req_tdata[VALUE_W-1:0];
      next_in         = next_ff;
      if (req_tlast) begin
         work_data.op = OP_LAST;
         next_in      = '0;
      end else if (next_ff == INDEX_W'(MAX_NODES - 1)) begin
         // successor would run past the index space: index holds
         work_data.op = OP_FULL;
      end else begin
         next_in = next_ff + 1'b1;
         if (!no_child) begin
            work_data.op = no_sibling ? OP_CHILD : OP_CHILD_PUSH;
         end else begin
            work_data.op = no_sibling ? OP_POP : OP_SELF_LINK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= '0;
      end else if (accept) begin
         next_ff <= next_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/dtptb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtptb_back
   import dtptb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           work_valid,
   output logic                work_ready,
   input  wire work_type       work_data,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [INDEX_W-1:0]    top_ff, top_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  take;
   logic                  wr_en;
   logic [STACK_AW-1:0]   wr_addr, rd_addr;
   logic [INDEX_W-1:0]    below_data;
   logic [INDEX_W-1:0]    succ, child_index, link_owner, link_target;
   logic                  child_present, link_valid, unterminated;
   err_type               error_code;

   // the ram always holds the entry under the top register for the next cycle
   dtptb_ram #(
      .WIDTH (INDEX_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (work_data.index),
      .rd_addr (rd_addr),
      .rd_data (below_data)
   );

   assign work_ready = !rsp_valid_ff || rsp_tready;
   assign take       = work_valid && work_ready;
   assign succ       = work_data.index + 1'b1;
   assign wr_addr    = count_ff[STACK_AW-1:0];
   assign rd_addr    = STACK_AW'(count_in - COUNT_W'(2));

   always_comb begin
      count_in      = count_ff;
      top_in        = top_ff;
      wr_en         = 1'b0;
      child_present = 1'b0;
      child_index   = '0;
      link_valid    = 1'b0;
      link_owner    = '0;
      link_target   = '0;
      error_code    = ERR_NONE;
      unterminated  = 1'b0;
      if (take) begin
         case (work_data.op)
            OP_CHILD: begin
               child_present = 1'b1;
               child_index   = succ;
            end
            OP_CHILD_PUSH: begin
               child_present = 1'b1;
               child_index   = succ;
               if (count_ff < COUNT_W'(STACK_DEPTH)) begin
                  wr_en    = 1'b1;
                  top_in   = work_data.index;
                  count_in = count_ff + 1'b1;
               end else begin
                  error_code = ERR_OVERFLOW;
               end
            end
            OP_SELF_LINK: begin
               link_valid  = 1'b1;
               link_owner  = work_data.index;
               link_target = succ;
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  error_code = ERR_UNDERFLOW;
               end else begin
                  link_valid  = 1'b1;
                  link_owner  = top_ff;
                  link_target = succ;
                  top_in      = below_data;
                  count_in    = count_ff - 1'b1;
               end
            end
            OP_FULL: begin
               error_code = ERR_TOO_MANY;
            end
            OP_LAST: begin
               unterminated = (count_ff != '0);
               count_in     = '0;
            end
            default: begin
               error_code = ERR_NONE;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}}, unterminated, error_code,
                     link_target, link_owner, link_valid, child_index, child_present,
                     work_data.value, work_data.index};
      rsp_last_in = (work_data.op == OP_LAST);
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (take) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

@@ rtl/core/dtptb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtptb_checker
   import dtptb_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   logic [INDEX_W-1:0] node_index, child_index, link_owner, link_target, succ;
   logic               child_present, link_valid;
   logic [1:0]         error_code;

   assign node_index    = rsp_tdata[INDEX_W-1:0];
   assign child_present = rsp_tdata[18];
   assign child_index   = rsp_tdata[28:19];
   assign link_valid    = rsp_tdata[29];
   assign link_owner    = rsp_tdata[39:30];
   assign link_target   = rsp_tdata[49:40];
   assign error_code    = rsp_tdata[51:50];
   assign succ          = node_index + 1'b1;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_child_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && child_present |-> child_index == succ)
      else $error("child index is not the next index");

   a_link_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && link_valid |-> link_target == succ && link_owner <= node_index)
      else $error("sibling link does not point at the next index");

   a_no_link_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !link_valid |-> link_owner == '0 && link_target == '0)
      else $error("link fields set without a link");

   a_last_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !child_present && !link_valid && error_code == ERR_NONE)
      else $error("last node carries a link or an error");

endmodule

bind dual_tag_preorder_tree_builder dtptb_checker u_checker (.*);
`default_nettype wire

@@ bench/dual_tag_preorder_tree_builder_test.sv @@
`timescale 1ns / 1ps
module dual_tag_preorder_tree_builder_test;
   import dtptb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEM_COUNT  = 1700;
   localparam int CALM_FROM   = 1450;

   // one result as it leaves the block, lowest field last; end_of_tree rides on tlast
   typedef struct packed {
      logic                             end_of_tree;
      logic [RSP_DATA_W-RSP_FIELD_W-1:0] fill;
      logic                             unterminated;
      err_type                          error_code;
      logic [INDEX_W-1:0]               link_target;
      logic [INDEX_W-1:0]               link_owner;
      logic                             link_valid;
      logic [INDEX_W-1:0]               child_index;
      logic                             child_present;
      logic [VALUE_W-1:0]               value;
      logic [INDEX_W-1:0]               index;
   } node_result;

   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 no_child;
      bit                 no_sib;
      bit                 is_last;
      bit                 typed;
      node_result         want;
   } stim_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // mirror of the tree builder state
   logic [INDEX_W-1:0] pend_ids [STACK_DEPTH];
   int                 pend_count = 0;
   logic [INDEX_W-1:0] index_next = '0;

   node_result expected_nodes [$];
   int         fail_count = 0;
   int         sent_count = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   bit         calm_tail = 1'b0;
   stim_row    directed_rows [14];

   dual_tag_preorder_tree_builder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic node_result build_node(input logic [VALUE_W-1:0] value,
                                             input bit no_child, input bit no_sib,
                                             input bit is_last);
      node_result       r;
      logic [INDEX_W:0] succ;
      r = '0;
      r.index = index_next;
      r.value = value;
      r.error_code = ERR_NONE;
      succ = index_next + 1'b1;
      if (is_last) begin
         r.end_of_tree = 1'b1;
         r.unterminated = (pend_count != 0);
         pend_count = 0;
         index_next = '0;
      end else if (succ >= MAX_NODES) begin
         r.error_code = ERR_TOO_MANY;
      end else begin
         if (!no_child) begin
            r.child_present = 1'b1;
            r.child_index = succ[INDEX_W-1:0];
            if (!no_sib) begin
               if (pend_count < STACK_DEPTH) begin
                  pend_ids[pend_count] = index_next;
                  pend_count++;
               end else begin
                  r.error_code = ERR_OVERFLOW;
               end
            end
         end else if (!no_sib) begin
            // leaf with a sibling settles its own link
            r.link_valid = 1'b1;
            r.link_owner = index_next;
            r.link_target = succ[INDEX_W-1:0];
         end else if (pend_count == 0) begin
            r.error_code = ERR_UNDERFLOW;
         end else begin
            pend_count--;
            r.link_valid = 1'b1;
            r.link_owner = pend_ids[pend_count];
            r.link_target = succ[INDEX_W-1:0];
         end
         index_next = succ[INDEX_W-1:0];
      end
      return r;
   endfunction

   function automatic node_result plain_result(input int index, input logic [VALUE_W-1:0] value,
                                               input err_type code, input bit eot,
                                               input bit unterm);
      node_result r;
      r = '0;
      r.index = INDEX_W'(index);
      r.value = value;
      r.error_code = code;
      r.end_of_tree = eot;
      r.unterminated = unterm;
      return r;
   endfunction

   function automatic string result_text(input node_result r);
      return $sformatf("idx=%0d val=%02h child=%0d/%0d link=%0d/%0d->%0d err=%0d end=%0d unterm=%0d",
                       r.index, r.value, r.child_present, r.child_index, r.link_valid,
                       r.link_owner, r.link_target, r.error_code, r.end_of_tree,
                       r.unterminated);
   endfunction

   // called at a rising edge; returns at the edge that accepts the transaction
   task automatic send_node(input logic [VALUE_W-1:0] value, input bit no_child,
                            input bit no_sib, input bit is_last,
                            input bit typed = 1'b0, input node_result want = '0);
      node_result predicted;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W-VALUE_W-2){1'b0}}, no_sib, no_child, value};
      req_tlast <= is_last;
      do @(posedge clock); while (!req_tready);
      predicted = build_node(value, no_child, no_sib, is_last);
      expected_nodes.push_back(typed ? want : predicted);
      sent_count++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_nodes.size() != 0) @(posedge clock);
   endtask

   // one tree in preorder; pushes opens with a chain of nodes that have child and sibling
   task automatic emit_tree(input int size, input int pushes, input bit may_cut);
      int depth;
      int count;
      int cut_at;
      bit done;
      depth = pushes;
      count = pushes;
      done = 1'b0;
      repeat (pushes) send_node(VALUE_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
      cut_at = (may_cut && $urandom_range(0, 4) == 0) ? $urandom_range(pushes + 1, size) : -1;
      while (!done) begin
         if (count == cut_at) begin
            // broken sequence: tree may end with nodes still pending
            send_node(VALUE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b1);
            done = 1'b1;
         end else if (count >= size) begin
            if (depth == 0) begin
               if ($urandom_range(0, 3) == 0)
                  send_node(VALUE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b1);
               else
                  send_node(VALUE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b1);
               done = 1'b1;
            end else begin
               send_node(VALUE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
               depth--;
            end
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  send_node(VALUE_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
                  depth++;
               end
               1: send_node(VALUE_W'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
               2: send_node(VALUE_W'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
               default: begin
                  if (depth == 0) begin
                     send_node(VALUE_W'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
                  end else begin
                     send_node(VALUE_W'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0);
                     depth--;
                  end
               end
            endcase
         end
         count++;
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      node_result got;
      node_result want;
      string      bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = node_result'({rsp_tlast, rsp_tdata});
         if (expected_nodes.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected rsp transaction: %s", result_text(got));
            fail_count++;
         end else begin
            want = expected_nodes.pop_front();
            bad = "";
            if (got.index !== want.index) bad = {bad, " node_index"};
            if (got.value !== want.value) bad = {bad, " node_value_out"};
            if (got.child_present !== want.child_present) bad = {bad, " child_present"};
            if (got.child_index !== want.child_index) bad = {bad, " child_index"};
            if (got.link_valid !== want.link_valid) bad = {bad, " link_valid"};
            if (got.link_owner !== want.link_owner) bad = {bad, " link_owner"};
            if (got.link_target !== want.link_target) bad = {bad, " link_target"};
            if (got.error_code !== want.error_code) bad = {bad, " error_code"};
            if (got.end_of_tree !== want.end_of_tree) bad = {bad, " end_of_tree"};
            if (got.unterminated !== want.unterminated) bad = {bad, " unterminated"};
            if (bad != "") begin
               if (fail_count < 10) begin
                  $display("mismatch in%s", bad);
                  $display("   expected %s", result_text(want));
                  $display("   actual   %s", result_text(got));
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int  pushes;
      bit  long_done;
      long_done = 1'b0;
      directed_rows = '{
         '{8'h00, 1'b1, 1'b1, 1'b0, 1'b1, plain_result(0, 8'h00, ERR_UNDERFLOW, 1'b0, 1'b0)},
         '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, '0},
         '{8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, '0},
         '{8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, '0},
         '{8'hC3, 1'b1, 1'b1, 1'b0, 1'b0, '0},
         '{8'h81, 1'b0, 1'b0, 1'b0, 1'b0, '0},
         '{8'h7E, 1'b1, 1'b1, 1'b1, 1'b1, plain_result(6, 8'h7E, ERR_NONE, 1'b1, 1'b1)},
         '{8'h01, 1'b0, 1'b0, 1'b1, 1'b1, plain_result(0, 8'h01, ERR_NONE, 1'b1, 1'b0)},
         '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0, '0},
         '{8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, '0},
         '{8'h55, 1'b1, 1'b1, 1'b0, 1'b0, '0},
         '{8'hAA, 1'b1, 1'b1, 1'b0, 1'b1, plain_result(3, 8'hAA, ERR_UNDERFLOW, 1'b0, 1'b0)},
         '{8'hFE, 1'b1, 1'b0, 1'b1, 1'b1, plain_result(4, 8'hFE, ERR_NONE, 1'b1, 1'b0)},
         '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1, plain_result(0, 8'h00, ERR_NONE, 1'b1, 1'b0)}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_node(directed_rows[i].value, directed_rows[i].no_child, directed_rows[i].no_sib,
                   directed_rows[i].is_last, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      while (sent_count < ITEM_COUNT) begin
         calm_tail = (sent_count >= CALM_FROM);
         if (!long_done && sent_count >= 200) begin
            // runs the index counter into the node limit
            emit_tree(MAX_NODES + 16, 0, 1'b0);
            long_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(4, 16))
                     send_node(VALUE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
               1: begin
                  // deep chains, about half of them past the stack depth
                  pushes = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
                  emit_tree(pushes + $urandom_range(4, 20), pushes, 1'b0);
               end
               default: emit_tree($urandom_range(2, 40), 0, 1'b1);
            endcase
         end
         if (!calm_tail && $urandom_range(0, 9) == 0) drain_results();
      end

      req_tvalid <= 1'b0;
      while (expected_nodes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_nodes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
